FILE: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find/replace block
// Window and config sizes, register indexes, emit states, result word.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int MAX_REPLACE = 16;
    localparam int NUM_CELLS   = MAX_PATTERN;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int RIDX_W      = $clog2(MAX_REPLACE);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int HALF_BYTES  = CFG_DATA_W / 8;

    typedef logic [7:0]            t_byte;
    typedef logic [LEN_W-1:0]      t_len;
    typedef logic [RIDX_W-1:0]     t_ridx;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_PAT_LO  = 3'd0;
    localparam t_cfg_idx CFG_PAT_HI  = 3'd1;
    localparam t_cfg_idx CFG_PAT_LEN = 3'd2;
    localparam t_cfg_idx CFG_REP_LO  = 3'd3;
    localparam t_cfg_idx CFG_REP_HI  = 3'd4;
    localparam t_cfg_idx CFG_REP_LEN = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_REPL,
        ST_BARE
    } t_state;

    typedef struct packed {
        t_byte data;
        logic  valid;
        logic  run_last;
        logic  stream_end;
    } t_result;

endpackage

FILE: rtl/sfr_cell.sv
// ----------------------------------------------------------------------------
// sfr_cell: one window byte
// Holds a byte, shifts in its upper neighbor, loads a new text byte and
// compares its (post-shift) byte with its pattern byte.
// ----------------------------------------------------------------------------
module sfr_cell (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic          i_shift,
    input  logic          i_sel,
    input  sfr_pkg::t_byte i_byte,
    input  sfr_pkg::t_byte i_nbr,
    input  sfr_pkg::t_byte i_pat,
    output sfr_pkg::t_byte o_byte,
    output logic          o_eq
);
    import sfr_pkg::*;

    t_byte r_byte;
    t_byte n_byte;
    t_byte view;
    t_byte cmp;

    // view: content after this cycle's shift; a selected cell sees the new byte
    assign view   = i_shift ? i_nbr : r_byte;
    assign cmp    = i_sel ? i_byte : view;
    assign o_eq   = (cmp == i_pat);
    assign n_byte = i_load ? i_byte : view;
    assign o_byte = r_byte;

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

FILE: rtl/sfr_out_reg.sv
// ----------------------------------------------------------------------------
// sfr_out_reg: output word register
// Single-entry register with valid/ready; free when empty or being taken.
// ----------------------------------------------------------------------------
module sfr_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  sfr_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output sfr_pkg::t_result o_res
);
    import sfr_pkg::*;

    logic    r_vld;
    logic    n_vld;
    t_result r_res;

    assign o_free  = !r_vld || i_ready;
    assign n_vld   = i_load || (r_vld && !i_ready);
    assign o_valid = r_vld;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: rtl/stream_find_replace.sv
// ----------------------------------------------------------------------------
// stream_find_replace: streaming byte find-and-replace
// Replaces leftmost non-overlapping pattern hits in a byte stream.
// ----------------------------------------------------------------------------
// Text bytes enter one word per cycle as long as each byte causes at most one
// output word and the output is free. A byte that causes more than one output
// word (a replacement burst, a drain of the window at end of text or after the
// pattern was shortened) holds input off: the single output register takes at
// most one word per cycle, and the next byte is taken in the cycle that the
// item's last word is loaded. The output register decouples the two sides, so
// a byte is taken while a finished word still waits downstream. Configuration
// is written through a plain write port (no read-back) and must only change
// while the block is idle. A final byte that leaves nothing to emit (a hit
// with an empty replacement) yields one word with o_out_valid low, carrying
// the run and stream end marks. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module stream_find_replace (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config write port
    input  logic                i_cfg_we,
    input  sfr_pkg::t_cfg_idx   i_cfg_index,
    input  sfr_pkg::t_cfg_data  i_cfg_data,
    // text input
    input  logic                i_valid,
    output logic                o_ready,
    input  sfr_pkg::t_byte      i_text_byte,
    input  logic                i_text_end,
    // result output
    output logic                o_valid,
    input  logic                i_ready,
    output sfr_pkg::t_byte      o_out_byte,
    output logic                o_out_valid,
    output logic                o_run_last,
    output logic                o_stream_end
);
    import sfr_pkg::*;

    // ---------------- configuration registers ----------------
    t_cfg_data r_pat_lo, r_pat_hi, r_rep_lo, r_rep_hi;
    t_len      r_pat_len, r_rep_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= LEN_W'(1);
            r_rep_lo  <= '0;
            r_rep_hi  <= '0;
            r_rep_len <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                CFG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                CFG_PAT_LEN: r_pat_len <= i_cfg_data[LEN_W-1:0];
                CFG_REP_LO:  r_rep_lo  <= i_cfg_data;
                CFG_REP_HI:  r_rep_hi  <= i_cfg_data;
                CFG_REP_LEN: r_rep_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective lengths: pattern clamped to 1..MAX, replacement to 0..MAX
    t_len pat_len;
    t_len rep_len;

    always_comb begin
        if (r_pat_len == '0) begin
            pat_len = LEN_W'(1);
        end else if (r_pat_len > LEN_W'(MAX_PATTERN)) begin
            pat_len = LEN_W'(MAX_PATTERN);
        end else begin
            pat_len = r_pat_len;
        end
        if (r_rep_len > LEN_W'(MAX_REPLACE)) begin
            rep_len = LEN_W'(MAX_REPLACE);
        end else begin
            rep_len = r_rep_len;
        end
    end

    // byte views of pattern and replacement
    t_byte pat_bytes [NUM_CELLS];
    t_byte rep_bytes [MAX_REPLACE];

    always_comb begin
        for (int i = 0; i < NUM_CELLS; i++) begin
            if (i < HALF_BYTES) begin
                pat_bytes[i] = r_pat_lo[8*(i % HALF_BYTES) +: 8];
            end else begin
                pat_bytes[i] = r_pat_hi[8*(i % HALF_BYTES) +: 8];
            end
        end
        for (int i = 0; i < MAX_REPLACE; i++) begin
            if (i < HALF_BYTES) begin
                rep_bytes[i] = r_rep_lo[8*(i % HALF_BYTES) +: 8];
            end else begin
                rep_bytes[i] = r_rep_hi[8*(i % HALF_BYTES) +: 8];
            end
        end
    end

    // ---------------- emit control ----------------
    t_state r_state, n_state;
    t_len   r_rem,   n_rem;      // words left for the current item
    t_ridx  r_ridx,  n_ridx;     // next replacement byte
    logic   r_end,   n_end;      // current item is the final byte
    t_len   r_fill,  n_fill;     // bytes held in the window

    logic    out_free;
    logic    emit;
    logic    drain_now;
    logic    last_now;
    logic    accept;
    t_len    fill_view;
    t_len    n_cnt;
    t_len    drain_cnt;
    logic    hit;
    t_result res;

    t_byte             win   [NUM_CELLS];
    logic [NUM_CELLS-1:0] cell_eq;
    logic [NUM_CELLS-1:0] cell_use;

    assign emit      = (r_state != ST_IDLE) && out_free;
    assign drain_now = emit && (r_state == ST_DRAIN);
    assign last_now  = emit && (r_rem == LEN_W'(1));
    // fill as seen after this cycle's shift
    assign fill_view = r_fill - LEN_W'(drain_now);
    assign o_ready   = (r_state == ST_IDLE) || last_now;
    assign accept    = i_valid && o_ready;
    assign n_cnt     = fill_view + LEN_W'(1);

    // ---------------- window cells ----------------
    for (genvar gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
        t_byte nbr;
        logic  sel;

        if (gi == NUM_CELLS - 1) begin : g_top
            assign nbr = '0;
        end else begin : g_mid
            assign nbr = win[gi+1];
        end

        assign sel          = (fill_view == LEN_W'(gi));
        assign cell_use[gi] = (LEN_W'(gi) < pat_len);

        sfr_cell u_cell (
            .i_clk   (i_clk),
            .i_load  (accept && sel),
            .i_shift (drain_now),
            .i_sel   (sel),
            .i_byte  (i_text_byte),
            .i_nbr   (nbr),
            .i_pat   (pat_bytes[gi]),
            .o_byte  (win[gi]),
            .o_eq    (cell_eq[gi])
        );
    end

    // compare only when the window (with the new byte) is exactly pattern long
    assign hit = (n_cnt == pat_len) && (&(cell_eq | ~cell_use));

    // oldest bytes to give up for this byte
    always_comb begin
        if (i_text_end) begin
            drain_cnt = n_cnt;
        end else if (n_cnt == pat_len) begin
            drain_cnt = LEN_W'(1);
        end else if (n_cnt > pat_len) begin
            drain_cnt = n_cnt - pat_len + LEN_W'(1);
        end else begin
            drain_cnt = '0;
        end
    end

    // next state, counters and window fill
    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_ridx  = r_ridx;
        n_end   = r_end;
        n_fill  = fill_view;

        if (emit) begin
            n_rem = r_rem - LEN_W'(1);
            if (r_state == ST_REPL) begin
                n_ridx = r_ridx + RIDX_W'(1);
            end
            if (r_rem == LEN_W'(1)) begin
                n_state = ST_IDLE;
            end
        end

        if (accept) begin
            n_end  = i_text_end;
            n_ridx = '0;
            if (hit) begin
                n_fill = '0;
                if (rep_len != '0) begin
                    n_state = ST_REPL;
                    n_rem   = rep_len;
                end else if (i_text_end) begin
                    n_state = ST_BARE;
                    n_rem   = LEN_W'(1);
                end else begin
                    n_state = ST_IDLE;
                    n_rem   = '0;
                end
            end else begin
                n_fill = n_cnt;
                if (drain_cnt != '0) begin
                    n_state = ST_DRAIN;
                    n_rem   = drain_cnt;
                end else begin
                    n_state = ST_IDLE;
                    n_rem   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rem   <= '0;
            r_ridx  <= '0;
            r_end   <= 1'b0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_rem   <= n_rem;
            r_ridx  <= n_ridx;
            r_end   <= n_end;
            r_fill  <= n_fill;
        end
    end

    // ---------------- result word ----------------
    always_comb begin
        case (r_state)
            ST_DRAIN: res.data = win[0];
            ST_REPL:  res.data = rep_bytes[r_ridx];
            default:  res.data = '0;
        endcase
        res.valid      = (r_state != ST_BARE);
        res.run_last   = (r_rem == LEN_W'(1));
        res.stream_end = (r_rem == LEN_W'(1)) && r_end;
    end

    t_result out_res;

    sfr_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit),
        .i_res   (res),
        .i_ready (i_ready),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_out_byte   = out_res.data;
    assign o_out_valid  = out_res.valid;
    assign o_run_last   = out_res.run_last;
    assign o_stream_end = out_res.stream_end;

endmodule

FILE: tb/sfr_tb_pkg.sv
// ----------------------------------------------------------------------------
// sfr_tb_pkg: byte-level rewrite predictor and result board
// Mirrors the find/replace window in plain code and checks each output word
// against the oldest word still owed.
// ----------------------------------------------------------------------------
package sfr_tb_pkg;

    import sfr_pkg::*;

    class rewrite_checker;

        t_cfg_data   pat_lo, pat_hi, rep_lo, rep_hi;
        logic [4:0]  pat_len, rep_len;
        t_byte       window [NUM_CELLS];
        int unsigned fill;
        t_result     owed_words [$];
        int unsigned errors;
        int unsigned words_seen;

        function new();
            pat_lo  = '0;
            pat_hi  = '0;
            pat_len = 5'd1;
            rep_lo  = '0;
            rep_hi  = '0;
            rep_len = 5'd0;
            foreach (window[i]) window[i] = '0;
            fill       = 0;
            errors     = 0;
            words_seen = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, t_cfg_data data);
            case (idx)
                CFG_PAT_LO:  pat_lo  = data;
                CFG_PAT_HI:  pat_hi  = data;
                CFG_PAT_LEN: pat_len = data[4:0];
                CFG_REP_LO:  rep_lo  = data;
                CFG_REP_HI:  rep_hi  = data;
                CFG_REP_LEN: rep_len = data[4:0];
                default: ;
            endcase
        endfunction

        // zero acts as one, anything past the window clamps
        function int unsigned pattern_len();
            if (pat_len == 0) return 1;
            if (pat_len > MAX_PATTERN) return MAX_PATTERN;
            return pat_len;
        endfunction

        function int unsigned replace_len();
            if (rep_len > MAX_REPLACE) return MAX_REPLACE;
            return rep_len;
        endfunction

        function t_byte pick(t_cfg_data lo, t_cfg_data hi, int unsigned i);
            if (i < HALF_BYTES) return lo[8*i +: 8];
            return hi[8*(i - HALF_BYTES) +: 8];
        endfunction

        function t_byte pattern_byte(int unsigned i);
            return pick(pat_lo, pat_hi, i);
        endfunction

        function void owe(t_byte b, logic has_byte);
            t_result w;
            w.data       = b;
            w.valid      = has_byte;
            w.run_last   = 1'b0;
            w.stream_end = 1'b0;
            owed_words.push_back(w);
        endfunction

        // emit the k oldest window bytes, shift the rest down, return new fill
        function int unsigned shift_out(int unsigned n, int unsigned k);
            if (k > n) k = n;
            for (int unsigned i = 0; i < k; i++) owe(window[i], 1'b1);
            for (int unsigned i = 0; i + k < n; i++) window[i] = window[i + k];
            return n - k;
        endfunction

        // one accepted text word: append the words it must produce
        function void take_byte(t_byte b, logic last);
            int unsigned plen, rlen, n, first_new;
            bit          hit;
            t_result     w;
            plen      = pattern_len();
            rlen      = replace_len();
            first_new = owed_words.size();
            window[fill] = b;
            n = fill + 1;
            if (n == plen) begin
                hit = 1'b1;
                for (int unsigned i = 0; i < plen; i++)
                    if (window[i] != pattern_byte(i)) hit = 1'b0;
                if (hit) begin
                    for (int unsigned i = 0; i < rlen; i++)
                        owe(pick(rep_lo, rep_hi, i), 1'b1);
                    n = 0;
                end else if (!last) begin
                    n = shift_out(n, 1);
                end
            end else if (n > plen && !last) begin
                // pattern got shorter under a part-filled window
                n = shift_out(n, n - plen + 1);
            end
            if (last) begin
                n = shift_out(n, n);
                if (owed_words.size() == first_new) owe(8'h00, 1'b0);
            end
            fill = n;
            if (owed_words.size() > first_new) begin
                w = owed_words.pop_back();
                w.run_last   = 1'b1;
                w.stream_end = last;
                owed_words.push_back(w);
            end
        endfunction

        function void flag(string what, t_result want, t_result got);
            errors++;
            if (errors <= 10)
                $display("word %0d %s: expected %02h/%b/%b/%b got %02h/%b/%b/%b",
                         words_seen, what, want.data, want.valid, want.run_last,
                         want.stream_end, got.data, got.valid, got.run_last,
                         got.stream_end);
        endfunction

        function void check_word(t_result got);
            t_result want;
            words_seen++;
            if (owed_words.size() == 0) begin
                flag("unexpected", '0, got);
                return;
            end
            want = owed_words.pop_front();
            if (got.data != want.data || got.valid != want.valid ||
                got.run_last != want.run_last || got.stream_end != want.stream_end)
                flag("mismatch", want, got);
        endfunction

        function void close();
            if (owed_words.size() != 0) begin
                errors += owed_words.size();
                $display("%0d expected words never arrived", owed_words.size());
            end
        endfunction

    endclass

endpackage

FILE: tb/tb_stream_find_replace.sv
// ----------------------------------------------------------------------------
// tb_stream_find_replace: self-checking bench for the stream find/replace
// Directed corner texts, then random phases: each phase loads a new pattern
// and replacement while idle and streams texts rich in full and partial hits.
// Both sides idle in random bursts; one phase holds the output off for a long
// stretch. Every output word is checked against a byte-level predictor.
// ----------------------------------------------------------------------------
module tb_stream_find_replace;

    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;
    import sfr_tb_pkg::*;

    localparam int RANDOM_WORDS  = 450;
    localparam int CALM_WORDS    = 60;   // tail of the run with no idling
    localparam int SETTLE_CYCLES = 8;    // quiet cycles before a config change
    localparam int HOLD_CYCLES   = 300;  // long output hold-off
    localparam int HOLD_PHASE    = 2;

    // indexes past the last register; writes there must change nothing
    localparam t_cfg_idx CFG_SPARE_A = 3'd6;
    localparam t_cfg_idx CFG_SPARE_B = 3'd7;

    typedef t_byte t_text [$];

    typedef struct {
        t_cfg_data  pat_lo;
        t_cfg_data  pat_hi;
        logic [4:0] pat_len;
        t_cfg_data  rep_lo;
        t_cfg_data  rep_hi;
        logic [4:0] rep_len;
    } t_setting;

    logic      clk         = 1'b0;
    logic      rst_n       = 1'b0;
    logic      cfg_we      = 1'b0;
    t_cfg_idx  cfg_index   = '0;
    t_cfg_data cfg_data    = '0;
    logic      word_valid  = 1'b0;
    logic      word_ready;
    t_byte     word_byte   = '0;
    logic      word_end    = 1'b0;
    logic      res_valid;
    logic      res_ready   = 1'b0;
    t_byte     res_byte;
    logic      res_has_byte;
    logic      res_run_last;
    logic      res_stream_end;

    // idling switches, owned by the stimulus process
    bit tx_idle  = 1'b0;
    bit rx_idle  = 1'b0;
    bit hold_req = 1'b0;

    rewrite_checker board = new();

    stream_find_replace i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_valid      (word_valid),
        .o_ready      (word_ready),
        .i_text_byte  (word_byte),
        .i_text_end   (word_end),
        .o_valid      (res_valid),
        .i_ready      (res_ready),
        .o_out_byte   (res_byte),
        .o_out_valid  (res_has_byte),
        .o_run_last   (res_run_last),
        .o_stream_end (res_stream_end)
    );

    initial begin : clock_gen
        forever #10 clk = ~clk;
    end

    // Worst correct run (~500 words x 16 results, output stalls, sender gaps and
    // the hold-off) takes about 1.2 ms.
    initial begin : watchdog
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

    // ---- output side -------------------------------------------------------
    // Words are sampled at the edge, before any NBA of this step lands.
    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready)
            board.check_word({res_byte, res_has_byte, res_run_last, res_stream_end});
    end

    // Ready pattern: a long hold-off on request, else random stall bursts
    // while rx_idle is set, else always ready.
    initial begin : receiver
        forever begin
            @(posedge clk);
            if (hold_req) begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_req = 1'b0;
            end else if (rx_idle && $urandom_range(0, 4) == 0) begin
                res_ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(posedge clk);
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    // ---- input side --------------------------------------------------------
    // Offer one text word and hold it until taken. A gap, if any, comes
    // before valid rises, so valid never drops under a pending word.
    task automatic send_word(t_byte b, logic last);
        if (tx_idle && $urandom_range(0, 4) == 0) begin
            word_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        word_valid <= 1'b1;
        word_byte  <= b;
        word_end   <= last;
        do @(posedge clk); while (!word_ready);
        board.take_byte(b, last);
    endtask

    // Sender pause: wait for every owed word, then a few quiet cycles in case
    // the last word taken produced nothing yet is still in flight.
    task automatic settle();
        word_valid <= 1'b0;
        while (board.owed_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_cfg_data data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    // length registers keep only 5 bits; junk above them now and then
    function automatic t_cfg_data len_word(logic [4:0] len);
        t_cfg_data w;
        w = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
        w[4:0] = len;
        return w;
    endfunction

    // back-to-back writes, write enable dropped once after the last
    task automatic load_setting(t_setting s);
        write_reg(CFG_PAT_LO, s.pat_lo);
        write_reg(CFG_PAT_HI, s.pat_hi);
        write_reg(CFG_PAT_LEN, len_word(s.pat_len));
        write_reg(CFG_REP_LO, s.rep_lo);
        write_reg(CFG_REP_HI, s.rep_hi);
        write_reg(CFG_REP_LEN, len_word(s.rep_len));
        if ($urandom_range(0, 2) == 0) begin
            write_reg(CFG_SPARE_A, {$urandom, $urandom});
            write_reg(CFG_SPARE_B, {$urandom, $urandom});
        end
        cfg_we <= 1'b0;
    endtask

    // Patterns are often built from three symbols so that partial hits and
    // self-overlap (e.g. "aab" inside "aaab") show up in the texts.
    function automatic t_setting random_setting();
        t_setting s;
        t_byte    sym [3];
        foreach (sym[i]) sym[i] = t_byte'($urandom);
        case ($urandom_range(0, 9))
            0:       s.pat_len = 5'd0;
            1:       s.pat_len = 5'($urandom_range(17, 31));
            2:       s.pat_len = 5'd16;
            default: s.pat_len = 5'($urandom_range(1, 6));
        endcase
        s.pat_lo = {$urandom, $urandom};
        s.pat_hi = {$urandom, $urandom};
        if ($urandom_range(0, 1)) begin
            for (int i = 0; i < HALF_BYTES; i++) begin
                s.pat_lo[8*i +: 8] = sym[$urandom_range(0, 2)];
                s.pat_hi[8*i +: 8] = sym[$urandom_range(0, 2)];
            end
        end
        case ($urandom_range(0, 7))
            0:       s.rep_len = 5'd0;
            1:       s.rep_len = 5'd16;
            2:       s.rep_len = 5'($urandom_range(17, 31));
            default: s.rep_len = 5'($urandom_range(0, 5));
        endcase
        s.rep_lo = {$urandom, $urandom};
        s.rep_hi = {$urandom, $urandom};
        return s;
    endfunction

    // Mostly well-formed text: whole pattern copies, cut-off prefixes and
    // pattern symbols; now and then a text of plain noise.
    function automatic t_text compose_text();
        t_text       txt;
        int unsigned plen, target, k;
        t_byte       alphabet [4];
        plen   = board.pattern_len();
        target = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4)
                                             : $urandom_range(5, 32);
        alphabet[0] = board.pattern_byte(0);
        alphabet[1] = board.pattern_byte(plen - 1);
        alphabet[2] = board.pattern_byte(plen / 2);
        alphabet[3] = t_byte'($urandom);
        if ($urandom_range(0, 6) == 0) begin
            repeat (target) txt.push_back(t_byte'($urandom));
            return txt;
        end
        while (txt.size() < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    for (int unsigned m = 0; m < plen; m++)
                        txt.push_back(board.pattern_byte(m));
                end
                3: begin
                    k = $urandom_range(1, plen);
                    for (int unsigned m = 0; m < k; m++)
                        txt.push_back(board.pattern_byte(m));
                end
                4:       txt.push_back(t_byte'($urandom));
                default: txt.push_back(alphabet[$urandom_range(0, 3)]);
            endcase
        end
        return txt;
    endfunction

    task automatic run_directed();
        t_setting s;
        // Reset registers: one-byte pattern 00, empty replacement, so zero
        // bytes vanish. A final byte that is deleted leaves a bare end mark.
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b1);
        settle();
        // widest pattern and replacement, a full 16-word burst with end mark
        s.pat_lo  = 64'h00FF_00FF_A55A_0FF0;
        s.pat_hi  = 64'hFF00_7E81_0000_FFFF;
        s.pat_len = 5'd16;
        s.rep_lo  = 64'hFFFF_FFFF_0000_0000;
        s.rep_hi  = 64'h0123_4567_89AB_CDEF;
        s.rep_len = 5'd16;
        load_setting(s);
        for (int i = 0; i < MAX_PATTERN; i++)
            send_word(board.pattern_byte(i), i == MAX_PATTERN - 1);
        settle();
        // pattern length zero acts as one; replacement length 31 clamps to 16
        s.pat_len = 5'd0;
        s.rep_len = 5'd31;
        load_setting(s);
        send_word(8'hF0, 1'b0);
        settle();
        // leave three bytes in the window, then shorten the pattern under them
        s.pat_len = 5'd4;
        s.rep_len = 5'd2;
        load_setting(s);
        send_word(8'h11, 1'b0);
        send_word(8'h22, 1'b0);
        send_word(8'h33, 1'b0);
        settle();
        s.pat_len = 5'd1;
        load_setting(s);
        send_word(8'h44, 1'b0);
        settle();
        // text ends on a partial window: both bytes flush out in order
        s.pat_len = 5'd3;
        load_setting(s);
        send_word(8'hF0, 1'b0);
        send_word(8'h5A, 1'b1);
        settle();
    endtask

    // ---- main sequence -----------------------------------------------------
    initial begin : stimulus
        t_text       txt;
        int unsigned sent, done, budget, phase;
        bit          leave_open, last_text;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            // every phase starts with the sender paused until all words are in
            settle();
            load_setting(random_setting());
            tx_idle = (sent + CALM_WORDS < RANDOM_WORDS) && $urandom_range(0, 3) != 0;
            rx_idle = (sent + CALM_WORDS < RANDOM_WORDS) && $urandom_range(0, 3) != 0;
            budget  = $urandom_range(15, 50);
            if (phase == HOLD_PHASE) begin
                // receiver holds off while words keep coming: the block fills up
                hold_req = 1'b1;
                tx_idle  = 1'b0;
                budget   = 60;
            end
            // sometimes the next config lands mid-text, window still part full
            leave_open = $urandom_range(0, 4) == 0;
            done = 0;
            while (done < budget) begin
                txt = compose_text();
                last_text = done + txt.size() >= budget;
                foreach (txt[j])
                    send_word(txt[j], j == txt.size() - 1 && !(last_text && leave_open));
                done += txt.size();
                sent += txt.size();
                if (sent + CALM_WORDS >= RANDOM_WORDS) begin
                    tx_idle = 1'b0;
                    rx_idle = 1'b0;
                end
            end
            phase++;
        end

        // drain, then give stray words a chance to show up
        word_valid <= 1'b0;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        while (board.owed_words.size() != 0) @(posedge clk);
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        board.close();
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: stream_find_replace.f
rtl/sfr_pkg.sv
rtl/sfr_cell.sv
rtl/sfr_out_reg.sv
rtl/stream_find_replace.sv
tb/sfr_tb_pkg.sv
tb/tb_stream_find_replace.sv
